/* design/matrix_multiply_engine_top_macros.svh */
// Assertion helpers for the matrix engine
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH

// Concurrent implication check, reset-qualified
`define MME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mme_pkg.sv */
package mme_pkg;
    localparam int MAX_DIM_DEF = 8;
    localparam int VAL_W = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W = 72;
    localparam int DIM_W = 4;

    localparam logic [1:0] ACT_WR_A = 2'd0;
    localparam logic [1:0] ACT_WR_B = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;

    // control passed down the cell chain with each product term
    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
        logic last_out;
        logic [2:0] row;
        logic [2:0] col;
    } mme_tag_t;
endpackage

/* design/mme_mul_cell.sv */
// Cell 1: registered signed multiply
module mme_mul_cell
    import mme_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mme_tag_t                tag_in,
    input  logic signed [VAL_W-1:0] a_in,
    input  logic signed [VAL_W-1:0] b_in,
    output mme_tag_t                tag_out,
    output logic signed [PROD_W-1:0] prod_out
);
    mme_tag_t tag_reg;
    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_in * b_in;
    end

    assign tag_out = tag_reg;
    assign prod_out = prod_reg;
endmodule

/* design/mme_acc_cell.sv */
// Cell 2: accumulate products; the top level floor-shifts and saturates the sum into the output register
module mme_acc_cell
    import mme_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mme_tag_t                 tag_in,
    input  logic signed [PROD_W-1:0] prod_in,
    output logic                     done,
    output mme_tag_t                 tag_out,
    output logic signed [ACC_W-1:0]  sum_out
);
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    mme_tag_t tag_reg;
    logic done_reg;

    always_comb
    begin
        if (tag_in.first)
        begin
            acc_next = ACC_W'(prod_in);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            tag_reg <= '0;
        end
        else
        begin
            done_reg <= tag_in.valid && tag_in.last_k;
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_in.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign tag_out = tag_reg;
    assign sum_out = acc_reg;
endmodule

/* design/matrix_multiply_engine_top.sv */
// Element writes: accepted back to back while idle, no result.
// Compute: rows*cols results through the shared multiply and accumulate cells.
// Results leave in row-major order; a full output register holds back the next
// result. Input is not taken while a product runs.
// Reset (rst_n, async low) sets dimensions to MAX_DIM; element stores are undefined.
module matrix_multiply_engine_top
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], row_index[4:2], col_index[7:5], element_value[39:8]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6], pad to 40
    output logic [39:0] m_tdata,
    // out_last
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    `include "matrix_multiply_engine_top_macros.svh"

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    logic [VAL_W-1:0] left_mem [DEPTH];
    logic [VAL_W-1:0] right_mem [DEPTH];

    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    state_t state_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [IW-1:0] nr, nk, nc;
    logic [1:0] act;
    logic [2:0] wr, wc;
    logic [VAL_W-1:0] wv;
    logic in_fire;

    logic [VAL_W-1:0] a_rd_reg, b_rd_reg;
    mme_tag_t rd_tag_reg, rd_tag_next, mul_tag, acc_tag;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] sum;
    logic done;

    logic out_v_reg;
    logic [2:0] out_r_reg, out_c_reg;
    logic [VAL_W-1:0] out_val_reg;
    logic out_last_reg;
    logic [VAL_W-1:0] sat;
    logic signed [ACC_W-17:0] shifted;
    logic issue;
    logic [2:0] inflight;

    function automatic logic [IW-1:0] clampm1(input logic [DIM_W-1:0] v,
                                              input logic [DIM_W-1:0] m);
        logic [DIM_W-1:0] t;
        t = (v == '0) ? DIM_W'(1) : ((v > m) ? m : v);
        return IW'(t - DIM_W'(1));
    endfunction

    assign nr = clampm1(rows_reg, MAXD);
    assign nk = clampm1(inner_reg, MAXD);
    assign nc = clampm1(cols_reg, MAXD);

    assign act = s_tdata[1:0];
    assign wr = s_tdata[4:2];
    assign wc = s_tdata[7:5];
    assign wv = s_tdata[39:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // one result may be in the pipe per output slot; stall on the last k term
    assign issue = (state_reg == ST_RUN) &&
                   !((k_reg == nk) && (out_v_reg || inflight != 3'd0));

    always_comb
    begin
        rd_tag_next = '0;
        if (issue)
        begin
            rd_tag_next.valid = 1'b1;
            rd_tag_next.first = (k_reg == '0);
            rd_tag_next.last_k = (k_reg == nk);
            rd_tag_next.last_out = (i_reg == nr) && (j_reg == nc);
            rd_tag_next.row = 3'(i_reg);
            rd_tag_next.col = 3'(j_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= MAXD;
            inner_reg <= MAXD;
            cols_reg <= MAXD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROWS:  rows_reg <= cfg_data;
                REG_INNER: inner_reg <= cfg_data;
                REG_COLS:  cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && 32'(wr) < MAX_DIM && 32'(wc) < MAX_DIM)
        begin
            if (act == ACT_WR_A)
            begin
                left_mem[AW'(32'(wr) * MAX_DIM + 32'(wc))] <= wv;
            end
            if (act == ACT_WR_B)
            begin
                right_mem[AW'(32'(wr) * MAX_DIM + 32'(wc))] <= wv;
            end
        end
        a_rd_reg <= left_mem[AW'(32'(i_reg) * MAX_DIM + 32'(k_reg))];
        b_rd_reg <= right_mem[AW'(32'(k_reg) * MAX_DIM + 32'(j_reg))];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            rd_tag_reg <= '0;
            inflight <= 3'd0;
        end
        else
        begin
            rd_tag_reg <= rd_tag_next;
            if (issue && k_reg == nk)
            begin
                inflight <= inflight + 3'd1;
            end
            else if (done)
            begin
                inflight <= inflight - 3'd1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    k_reg <= '0;
                    if (in_fire && act == ACT_COMPUTE)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        if (k_reg != nk)
                        begin
                            k_reg <= k_reg + IW'(1);
                        end
                        else
                        begin
                            k_reg <= '0;
                            if (j_reg != nc)
                            begin
                                j_reg <= j_reg + IW'(1);
                            end
                            else
                            begin
                                j_reg <= '0;
                                if (i_reg != nr)
                                begin
                                    i_reg <= i_reg + IW'(1);
                                end
                                else
                                begin
                                    state_reg <= ST_DRAIN;
                                end
                            end
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_v_reg && m_tready && m_tlast)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    mme_mul_cell u_mul (
        .clk(clk), .rst_n(rst_n), .tag_in(rd_tag_reg),
        .a_in(a_rd_reg), .b_in(b_rd_reg), .tag_out(mul_tag), .prod_out(prod)
    );

    mme_acc_cell u_acc (
        .clk(clk), .rst_n(rst_n), .tag_in(mul_tag), .prod_in(prod),
        .done(done), .tag_out(acc_tag), .sum_out(sum)
    );

    assign shifted = sum[ACC_W-1:16];
    always_comb
    begin
        priority if (shifted > $signed((ACC_W-16)'(32'sh7FFFFFFF)))
        begin
            sat = 32'h7FFFFFFF;
        end
        else if (shifted < -$signed((ACC_W-16)'(33'sh080000000)))
        begin
            sat = 32'h80000000;
        end
        else
        begin
            sat = shifted[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (done)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_r_reg <= acc_tag.row;
            out_c_reg <= acc_tag.col;
            out_val_reg <= sat;
            out_last_reg <= acc_tag.last_out;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {2'b00, out_val_reg, out_c_reg, out_r_reg};
    assign m_tlast = out_last_reg;

    `MME_ASSERT_IMPL(a_no_overrun, clk, rst_n, done, !out_v_reg || m_tready,
        "result overwrote a pending output")
    `MME_ASSERT_IMPL(a_busy_no_in, clk, rst_n, state_reg != ST_IDLE, !s_tready,
        "input accepted during compute")
    `MME_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready && !done,
        m_tvalid && $stable(m_tdata), "output changed while stalled")
endmodule

/* tb/tb_matrix_multiply_engine_top.sv */
`timescale 1ns / 100ps

module tb_matrix_multiply_engine_top;
    import mme_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int DIM = 8;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
    } product_elem_t;

    class product_scoreboard;
        logic [31:0] left_elems [DIM*DIM];
        logic [31:0] right_elems [DIM*DIM];
        logic [3:0] dim_reg [3];
        product_elem_t pending_elems [$];
        int mismatches;
        int elems_checked;
        int products_seen;

        function new();
            dim_reg[REG_ROWS] = 4'd8;
            dim_reg[REG_INNER] = 4'd8;
            dim_reg[REG_COLS] = 4'd8;
            mismatches = 0;
            elems_checked = 0;
            products_seen = 0;
        endfunction

        function int eff_dim(logic [1:0] idx);
            if (dim_reg[idx] == 0) return 1;
            if (dim_reg[idx] > DIM) return DIM;
            return int'(dim_reg[idx]);
        endfunction

        function logic [31:0] dot_q16(int r, int c, int n);
            logic signed [71:0] acc;
            logic signed [63:0] prod;
            logic signed [71:0] shifted;
            acc = '0;
            for (int k = 0; k < n; k++)
            begin
                prod = $signed(left_elems[r*DIM+k]) * $signed(right_elems[k*DIM+c]);
                acc = acc + prod;
            end
            shifted = acc >>> 16;
            if (shifted > 72'sh7FFFFFFF) return 32'h7FFFFFFF;
            if (shifted < -72'sh80000000) return 32'h80000000;
            return shifted[31:0];
        endfunction

        function void note_input(logic [39:0] item);
            logic [1:0] act;
            int r;
            int c;
            int rows;
            int cols;
            int n;
            product_elem_t e;
            act = item[1:0];
            r = int'(item[4:2]);
            c = int'(item[7:5]);
            if (act == ACT_WR_A) left_elems[r*DIM+c] = item[39:8];
            else if (act == ACT_WR_B) right_elems[r*DIM+c] = item[39:8];
            else if (act == ACT_COMPUTE)
            begin
                rows = eff_dim(REG_ROWS);
                n = eff_dim(REG_INNER);
                cols = eff_dim(REG_COLS);
                products_seen++;
                for (int i = 0; i < rows; i++)
                    for (int j = 0; j < cols; j++)
                    begin
                        e.row = 3'(i);
                        e.col = 3'(j);
                        e.value = dot_q16(i, j, n);
                        e.last = (i == rows-1) && (j == cols-1);
                        pending_elems = {pending_elems, e};
                    end
            end
        endfunction

        function void check_result(logic [39:0] data, logic last);
            product_elem_t e;
            if (pending_elems.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result row %0d col %0d value %h last %b",
                             data[2:0], data[5:3], data[37:6], last);
                return;
            end
            e = pending_elems.pop_front();
            elems_checked++;
            if (e.row !== data[2:0] || e.col !== data[5:3] || e.value !== data[37:6]
                || e.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp row %0d col %0d value %h last %b, got %0d %0d %h %b",
                             e.row, e.col, e.value, e.last,
                             data[2:0], data[5:3], data[37:6], last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    product_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  items_sent;
    bit  a_written [DIM*DIM];
    bit  b_written [DIM*DIM];

    matrix_multiply_engine_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function logic [31:0] pick_value();
        case ($urandom_range(6))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hFFFFFFFF;
            4: return {{12{$urandom_range(1)==1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [1:0] act, int r, int c, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, 3'(c), 3'(r), act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input({v, 3'(c), 3'(r), act});
        items_sent++;
        if (act == ACT_WR_A) a_written[r*DIM+c] = 1'b1;
        if (act == ACT_WR_B) b_written[r*DIM+c] = 1'b1;
    endtask

    task automatic write_dim(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.dim_reg[idx] = val;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_elems.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(logic [3:0] rows, logic [3:0] inner, logic [3:0] cols);
        drain();
        write_dim(REG_ROWS, rows);
        write_dim(REG_INNER, inner);
        write_dim(REG_COLS, cols);
    endtask

    // fill any operand element the product would read before it was written
    task automatic compute_product();
        int rows;
        int n;
        int cols;
        rows = sb.eff_dim(REG_ROWS);
        n = sb.eff_dim(REG_INNER);
        cols = sb.eff_dim(REG_COLS);
        for (int r = 0; r < rows; r++)
            for (int k = 0; k < n; k++)
                if (!a_written[r*DIM+k]) send_item(ACT_WR_A, r, k, pick_value());
        for (int k = 0; k < n; k++)
            for (int c = 0; c < cols; c++)
                if (!b_written[k*DIM+c]) send_item(ACT_WR_B, k, c, pick_value());
        send_item(ACT_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom);
    endtask

    initial
    begin
        logic [3:0] phase_dims [6][3];
        int pick;
        sb = new();
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturation both ways, sign extremes, unused action
        set_dims(4'd2, 4'd2, 4'd2);
        send_item(ACT_WR_A, 0, 0, 32'h7FFFFFFF);
        send_item(ACT_WR_A, 0, 1, 32'h7FFFFFFF);
        send_item(ACT_WR_A, 1, 0, 32'h80000000);
        send_item(ACT_WR_A, 1, 1, 32'hFFFFFFFF);
        send_item(ACT_WR_B, 0, 0, 32'h7FFFFFFF);
        send_item(ACT_WR_B, 0, 1, 32'h00010000);
        send_item(ACT_WR_B, 1, 0, 32'h7FFFFFFF);
        send_item(ACT_WR_B, 1, 1, 32'h00000001);
        send_item(ACT_UNUSED, 7, 7, 32'hFFFFFFFF);
        send_item(ACT_COMPUTE, 0, 0, 32'h0);
        send_item(ACT_WR_B, 0, 0, 32'h80000000);
        send_item(ACT_WR_B, 1, 0, 32'h80000000);
        send_item(ACT_COMPUTE, 7, 7, 32'hFFFFFFFF);
        set_dims(4'd0, 4'd1, 4'd15);
        send_item(ACT_WR_A, 7, 7, 32'h00018000);
        compute_product();

        phase_dims[0] = '{4'd8, 4'd8, 4'd8};
        phase_dims[1] = '{4'd1, 4'd1, 4'd1};
        phase_dims[2] = '{4'd0, 4'd15, 4'd4};
        phase_dims[3] = '{4'd3, 4'd8, 4'd5};
        phase_dims[4] = '{4'd15, 4'd0, 4'd8};
        phase_dims[5] = '{4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15))};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_dims(phase_dims[ph][0], phase_dims[ph][1], phase_dims[ph][2]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            while (items_sent < 16 + (ph + 1) * 76)
            begin
                pick = $urandom_range(99);
                if (pick < 10) compute_product();
                else if (pick < 14)
                    send_item(ACT_UNUSED, $urandom_range(7), $urandom_range(7), $urandom);
                else
                    send_item(pick[0] ? ACT_WR_A : ACT_WR_B, $urandom_range(7),
                              $urandom_range(7), pick_value());
            end
            compute_product();
        end

        drain();
        $display("Covered %0d input items, %0d products, %0d result elements checked",
                 items_sent, sb.products_seen, sb.elems_checked);
        $display("Dimension settings included 0, 1, 8 and 15; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("Timeout with %0d results still outstanding", sb.pending_elems.size());
        $display("status: fail");
        $finish;
    end
endmodule
